// ===== rtl/xfys_pkg.sv =====
`default_nettype none
package xfys_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = IDX_W + 1;

    localparam logic [31:0] SEED_X = 32'd123456789;
    localparam logic [31:0] SEED_Y = 32'd362436069;
    localparam logic [31:0] SEED_Z = 32'd521288629;
    localparam logic [31:0] SEED_W = 32'd88675123;

    typedef struct packed {
        logic signed [31:0] item_value;
        logic               item_last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic               out_last;
        logic               overflow_flag;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic             store;      // write input value at count
        logic             draw;       // advance generator, start modulo
        logic             div_step;   // one restoring step
        logic             rd_i;       // read entry i
        logic             rd_j;       // read entry j
        logic             wr_i;       // write entry i with entry j value
        logic             wr_j;       // write entry j with entry i value
        logic             rd_out;     // read entry at out index
        logic             out_load;   // load output register
        logic             clear;      // reset count, drop flag and out index
        logic             dec_i;      // i <- i-1
        logic             init_i;     // i <- count-1
        logic             inc_o;      // out index + 1
    } xfys_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic div_done;
        logic i_zero;
        logic o_last;
    } xfys_sts_t;

endpackage
`default_nettype wire

// ===== rtl/xfys_datapath.sv =====
`default_nettype none
module xfys_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire xfys_pkg::in_item_t  in_item,
    input  wire xfys_pkg::xfys_cmd_t cmd,
    output xfys_pkg::xfys_sts_t      sts,
    output xfys_pkg::out_item_t      out_item
);

    localparam int IW = xfys_pkg::IDX_W;
    localparam int CW = xfys_pkg::CNT_W;

    logic [31:0] gx_reg, gy_reg, gz_reg, gw_reg;
    logic [31:0] t_w, w_next;
    logic [CW-1:0] count_reg;
    logic          drop_reg;
    logic [IW-1:0] i_reg, o_reg;
    logic [31:0]   quo_reg;    // dividend shifting out
    logic [CW-1:0] rem_reg;
    logic [5:0]    step_reg;
    logic [31:0]   mem [xfys_pkg::MAX_ITEMS];
    logic [31:0]   rd_reg, vi_reg;
    logic [CW:0]   trial;
    logic [CW-1:0] divisor;

    assign t_w     = gx_reg ^ (gx_reg << 11);
    assign w_next  = gw_reg ^ (gw_reg >> 19) ^ t_w ^ (t_w >> 8);
    assign divisor = {1'b0, i_reg} + CW'(1);
    assign trial   = {rem_reg, quo_reg[31]} - {1'b0, divisor};

    // generator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gx_reg <= xfys_pkg::SEED_X;
            gy_reg <= xfys_pkg::SEED_Y;
            gz_reg <= xfys_pkg::SEED_Z;
            gw_reg <= xfys_pkg::SEED_W;
        end
        else if (cmd.draw)
        begin
            gx_reg <= gy_reg;
            gy_reg <= gz_reg;
            gz_reg <= gw_reg;
            gw_reg <= w_next;
        end
    end

    // list control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
            i_reg     <= '0;
            o_reg     <= '0;
            step_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
                drop_reg  <= 1'b0;
                o_reg     <= '0;
            end
            else if (cmd.store)
            begin
                if (sts.full)
                    drop_reg <= 1'b1;
                else
                    count_reg <= count_reg + CW'(1);
            end
            if (cmd.init_i)
                i_reg <= IW'(count_reg - CW'(1));
            else if (cmd.dec_i)
                i_reg <= i_reg - IW'(1);
            if (cmd.inc_o)
                o_reg <= o_reg + IW'(1);
            if (cmd.draw)
                step_reg <= '0;
            else if (cmd.div_step)
                step_reg <= step_reg + 6'd1;
        end
    end

    // restoring modulo, one bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.draw)
        begin
            quo_reg <= w_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            if (!trial[CW])
                rem_reg <= trial[CW-1:0];
            else
                rem_reg <= {rem_reg[CW-2:0], quo_reg[31]};
        end
    end

    // list memory, one port
    always_ff @(posedge clk)
    begin
        if (cmd.store && !sts.full)
            mem[count_reg[IW-1:0]] <= in_item.item_value;
        else if (cmd.wr_i)
            mem[i_reg] <= rd_reg;
        else if (cmd.wr_j)
            mem[rem_reg[IW-1:0]] <= vi_reg;
        if (cmd.rd_i)
            rd_reg <= mem[i_reg];
        else if (cmd.rd_j)
            rd_reg <= mem[rem_reg[IW-1:0]];
        else if (cmd.rd_out)
            rd_reg <= mem[o_reg];
        if (cmd.rd_j)
            vi_reg <= rd_reg;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item.out_value     <= rd_reg;
            out_item.out_last      <= sts.o_last;
            out_item.overflow_flag <= sts.o_last & drop_reg;
        end
    end

    assign sts.full     = (count_reg == CW'(xfys_pkg::MAX_ITEMS));
    assign sts.div_done = (step_reg == 6'd32);
    assign sts.i_zero   = (i_reg == '0);
    assign sts.o_last   = ({1'b0, o_reg} + CW'(1) == count_reg);

    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (sts.div_done && !cmd.draw) |-> rem_reg <= divisor - CW'(1))
        else $error("modulo out of range");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(xfys_pkg::MAX_ITEMS)) else $error("count overrun");
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.store && sts.full) |=> drop_reg) else $error("drop lost");

endmodule
`default_nettype wire

// ===== rtl/xfys_ctrl.sv =====
`default_nettype none
module xfys_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                in_last,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire xfys_pkg::xfys_sts_t sts,
    output xfys_pkg::xfys_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_DRAW, S_DIV, S_RDI, S_RDJ, S_WRI, S_WRJ,
        S_ORD, S_OLD, S_OWAIT
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (in_last)
                        state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init_i = 1'b1;
                state_next = S_DRAW;
            end
            S_DRAW:
            begin
                cmd.draw   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_RDI;
                else
                    cmd.div_step = 1'b1;
            end
            S_RDI:
            begin
                cmd.rd_i   = 1'b1;
                state_next = S_RDJ;
            end
            S_RDJ:
            begin
                cmd.rd_j   = 1'b1;
                state_next = S_WRI;
            end
            S_WRI:
            begin
                cmd.wr_i   = 1'b1;
                state_next = S_WRJ;
            end
            S_WRJ:
            begin
                cmd.wr_j = 1'b1;
                if (sts.i_zero)
                    state_next = S_ORD;
                else
                begin
                    cmd.dec_i  = 1'b1;
                    state_next = S_DRAW;
                end
            end
            S_ORD:
            begin
                cmd.rd_out = 1'b1;
                state_next = S_OLD;
            end
            S_OLD:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    if (sts.o_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_OWAIT;
                    end
                    else
                    begin
                        cmd.inc_o  = 1'b1;
                        state_next = S_ORD;
                    end
                end
            end
            S_OWAIT:
            begin
                if (out_ready)
                begin
                    ov_next    = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
        if (state_reg == S_ORD && ov_reg && out_ready)
            ov_next = 1'b0;
    end

    // hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    a_noin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> !in_ready) else $error("input open during shuffle");
    a_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OWAIT) |-> ov_reg) else $error("final item missing");
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW) |=> (state_reg == S_DIV)) else $error("draw skipped");

endmodule
`default_nettype wire

// ===== rtl/xorshift_fisher_yates_shuffler_core.sv =====
`default_nettype none
// Collects up to 64 values (later ones are dropped and flagged), then on
// the last item shuffles them with Fisher-Yates driven by xorshift128 and
// streams them out in index order, out_last on the final one. Loading
// accepts one item per cycle; each swap runs the bit-serial 32-step
// modulo and the single-port list memory read/write sequence; output
// reads each item, then loads it. Generator state persists across lists.
module xorshift_fisher_yates_shuffler_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire xfys_pkg::in_item_t   in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output xfys_pkg::out_item_t       out_item
);

    xfys_pkg::xfys_cmd_t cmd;
    xfys_pkg::xfys_sts_t sts;

    xfys_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_last   (in_item.item_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    xfys_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (out_item)
    );

endmodule
`default_nettype wire

// ===== tb/xorshift_fisher_yates_shuffler_core_tb.sv =====
`default_nettype none
module xorshift_fisher_yates_shuffler_core_tb;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    xfys_pkg::in_item_t  in_item;
    logic                out_valid;
    logic                out_ready;
    xfys_pkg::out_item_t out_item;

    xorshift_fisher_yates_shuffler_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    localparam int TIMEOUT_CYCLES = 20000;
    localparam int LONG_HOLD      = 3000;

    // shuffle model state
    logic [31:0] rng_x, rng_y, rng_z, rng_w;
    logic [31:0] list_mem [xfys_pkg::MAX_ITEMS];
    int          list_len;
    logic        list_dropped;

    xfys_pkg::out_item_t shuffled_q [$];
    xfys_pkg::out_item_t last_seen;
    int                  error_count = 0;
    int                  idle_cycles = 0;
    logic                rx_long_hold_req;

    // directed rows: value, last mark, typed check flag, typed expected value
    typedef struct {
        logic [31:0] value;
        logic        last;
        logic        has_exp;
        logic [31:0] exp_value;
    } stim_row_t;

    stim_row_t directed [$];

    // advance the xorshift128 generator and return the new w word
    function automatic logic [31:0] next_draw();
        logic [31:0] t;
        t = rng_x ^ (rng_x << 11);
        rng_x = rng_y;
        rng_y = rng_z;
        rng_z = rng_w;
        rng_w = (rng_w ^ (rng_w >> 19)) ^ (t ^ (t >> 8));
        return rng_w;
    endfunction

    // fold one accepted item into the model and queue any shuffled results
    task automatic predict_shuffle(input xfys_pkg::in_item_t it);
        logic [31:0]         j;
        logic [31:0]         tmp;
        xfys_pkg::out_item_t r;
        if (list_len < xfys_pkg::MAX_ITEMS)
        begin
            list_mem[list_len] = it.item_value;
            list_len++;
        end
        else
        begin
            list_dropped = 1'b1;
        end
        if (it.item_last)
        begin
            for (int i = list_len; i > 0; i--)
            begin
                j = next_draw() % i;
                tmp = list_mem[i-1];
                list_mem[i-1] = list_mem[j];
                list_mem[j] = tmp;
            end
            for (int i = 0; i < list_len; i++)
            begin
                r.out_value     = list_mem[i];
                r.out_last      = (i == list_len - 1);
                r.overflow_flag = (i == list_len - 1) ? list_dropped : 1'b0;
                shuffled_q.push_back(r);
            end
            list_len = 0;
            list_dropped = 1'b0;
        end
    endtask

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // check results against the model
    always @(posedge clk)
    begin
        xfys_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            last_seen = out_item;
            if (shuffled_q.size() == 0)
            begin
                $display("%0t: unexpected item value=%0d last=%0b ovf=%0b", $time,
                         out_item.out_value, out_item.out_last, out_item.overflow_flag);
                error_count++;
            end
            else
            begin
                want = shuffled_q.pop_front();
                if (out_item.out_value !== want.out_value)
                begin
                    $display("%0t: out_value expected %0d actual %0d", $time,
                             want.out_value, out_item.out_value);
                    error_count++;
                end
                if (out_item.out_last !== want.out_last)
                begin
                    $display("%0t: out_last expected %0b actual %0b", $time,
                             want.out_last, out_item.out_last);
                    error_count++;
                end
                if (out_item.overflow_flag !== want.overflow_flag)
                begin
                    $display("%0t: overflow_flag expected %0b actual %0b", $time,
                             want.overflow_flag, out_item.overflow_flag);
                    error_count++;
                end
            end
        end
    end

    // predict on input acceptance
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            predict_shuffle(in_item);
    end

    // watchdog: count cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= TIMEOUT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls per item, plus one long hold on request
    initial
    begin
        int gap;
        bit long_done;
        long_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_long_hold_req && !long_done)
            begin
                long_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // send one item and wait for acceptance; valid stays up for the next item
    task automatic send_item(input logic [31:0] v, input logic last, input bit idle_ok);
        int gap;
        gap = idle_ok ? $urandom_range(0, 19) : 0;
        if (idle_ok && $urandom_range(0, 2) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= xfys_pkg::in_item_t'{item_value: v, item_last: last};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // sender: directed table, full list with drops, long receiver hold, then random lists
    initial
    begin
        int          n;
        int          sent;
        logic [31:0] v;
        list_len = 0;
        list_dropped = 1'b0;
        rng_x = xfys_pkg::SEED_X;
        rng_y = xfys_pkg::SEED_Y;
        rng_z = xfys_pkg::SEED_Z;
        rng_w = xfys_pkg::SEED_W;
        rx_long_hold_req = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // one-entry list: the i=0 pass still draws, value comes back unchanged
        directed.push_back('{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000});
        // extremes and a short list
        directed.push_back('{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000});
        directed.push_back('{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000});
        directed.push_back('{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000});
        directed.push_back('{32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000});
        // two-entry list
        directed.push_back('{32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000});
        directed.push_back('{32'hAAAA_5555, 1'b1, 1'b0, 32'h0000_0000});
        foreach (directed[k])
        begin
            send_item(directed[k].value, directed[k].last, 1'b0);
            if (directed[k].has_exp)
            begin
                in_valid <= 1'b0;
                wait (shuffled_q.size() == 0);
                @(negedge clk);
                if (last_seen.out_value !== directed[k].exp_value ||
                    last_seen.out_last !== 1'b1 || last_seen.overflow_flag !== 1'b0)
                begin
                    $display("%0t: row %0d expected %h/1/0 actual %h/%0b/%0b", $time, k,
                             directed[k].exp_value, last_seen.out_value,
                             last_seen.out_last, last_seen.overflow_flag);
                    error_count++;
                end
            end
        end

        // full list plus dropped items, with the last one also dropped
        for (int k = 0; k < xfys_pkg::MAX_ITEMS + 3; k++)
            send_item($urandom, (k == xfys_pkg::MAX_ITEMS + 2), 1'b1);

        // pause until every shuffled item has drained
        in_valid <= 1'b0;
        wait (shuffled_q.size() == 0);
        @(negedge clk);

        // receiver holds off while the sender keeps offering items
        rx_long_hold_req = 1'b1;
        for (int k = 0; k < 8; k++)
            send_item($urandom, (k == 7), 1'b0);
        for (int k = 0; k < 4; k++)
            send_item($urandom, (k == 3), 1'b0);

        // random short lists
        sent = 0;
        while (sent < 34)
        begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
            begin
                v = $urandom;
                send_item(v, (k == n - 1), 1'b1);
            end
            sent += n;
        end

        in_valid <= 1'b0;
        wait (shuffled_q.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
